### hw/rtl/bmprle_pkg.sv
// ============================================================================
// bmprle_pkg: shared types and constants for the run-length pixel decoder
// Holds the parse phase codes, event kinds, the command passed from the
// parser to the output stage, and the configuration and queue status bundles.
// ============================================================================
package bmprle_pkg;

  // Default size limits and queue depth.
  localparam int unsigned MAX_WIDTH_DEF   = 4096;
  localparam int unsigned MAX_HEIGHT_DEF  = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Parser phase codes.
  localparam logic [1:0] PH_FIRST   = 2'd0;
  localparam logic [1:0] PH_SECOND  = 2'd1;
  localparam logic [1:0] PH_LITERAL = 2'd2;
  localparam logic [1:0] PH_PAD     = 2'd3;

  // Event kinds reported on the result channel.
  localparam logic [1:0] EV_RUN      = 2'd0;
  localparam logic [1:0] EV_DONE     = 2'd1;
  localparam logic [1:0] EV_DELTA    = 2'd2;
  localparam logic [1:0] EV_OVERFLOW = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Decoded configuration, with the size limits already applied.
  typedef struct packed {
    logic        mode;
    logic [11:0] eff_width;
    logic [11:0] eff_height;
  } cfg_t;

  // One command from the parser; row holds the file row, not yet flipped.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [7:0]  run_length;
    logic [7:0]  first_pixel;
    logic [7:0]  second_pixel;
  } cmd_t;

  // Queue status seen by the input stall logic, the back and the checks.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

### hw/rtl/bmprle_front.sv
// ============================================================================
// bmprle_front: byte parser of the run-length stream
// Tracks the pair phase, literal group progress, column and row, and turns
// each accepted byte into at most one command for the queue.
// ============================================================================
module bmprle_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic [7:0]          in_data_byte,
  input  logic                in_image_start,
  input  bmprle_pkg::cfg_t    cfg,
  output logic                push,
  output bmprle_pkg::cmd_t    push_cmd
);

  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  lit_r, lit_nxt;
  logic        pad_r, pad_nxt;
  logic [11:0] col_r, col_nxt;
  logic [11:0] row_r, row_nxt;
  logic        fin_r, fin_nxt;

  // State as seen by this byte, after an image start has cleared it.
  logic [1:0]  ph_c;
  logic [7:0]  held_c;
  logic [7:0]  lit_c;
  logic        pad_c;
  logic [11:0] col_c;
  logic [11:0] row_c;
  logic        fin_c;

  logic [3:0]  hi;
  logic [3:0]  lo;
  logic [12:0] col_held_sum;
  logic [12:0] col_byte_sum;
  logic [12:0] row_inc;
  logic [8:0]  byte_inc;
  logic [7:0]  lit_len;
  logic [7:0]  lit_rem;

  assign ph_c   = in_image_start ? bmprle_pkg::PH_FIRST : phase_r;
  assign held_c = in_image_start ? 8'd0 : held_r;
  assign lit_c  = in_image_start ? 8'd0 : lit_r;
  assign pad_c  = in_image_start ? 1'b0 : pad_r;
  assign col_c  = in_image_start ? 12'd0 : col_r;
  assign row_c  = in_image_start ? 12'd0 : row_r;
  assign fin_c  = in_image_start ? 1'b0 : fin_r;

  assign hi           = in_data_byte[7:4];
  assign lo           = in_data_byte[3:0];
  assign col_held_sum = {1'b0, col_c} + {5'd0, held_c};
  assign col_byte_sum = {1'b0, col_c} + {5'd0, in_data_byte};
  assign row_inc      = {1'b0, row_c} + 13'd1;
  assign byte_inc     = {1'b0, in_data_byte} + 9'd1;
  assign lit_len      = (cfg.mode && (lit_c >= 8'd2)) ? 8'd2 : 8'd1;
  assign lit_rem      = (lit_c >= lit_len) ? (lit_c - lit_len) : 8'd0;

  // Next state and command for the byte being accepted.
  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    lit_nxt   = lit_r;
    pad_nxt   = pad_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    fin_nxt   = fin_r;
    push      = 1'b0;
    push_cmd  = '0;
    push_cmd.row    = row_c;
    push_cmd.column = col_c;
    if (in_accept) begin
      phase_nxt = ph_c;
      held_nxt  = held_c;
      lit_nxt   = lit_c;
      pad_nxt   = pad_c;
      col_nxt   = col_c;
      row_nxt   = row_c;
      fin_nxt   = fin_c;
      if (!fin_c) begin
        case (ph_c)
          bmprle_pkg::PH_FIRST: begin
            held_nxt  = in_data_byte;
            phase_nxt = bmprle_pkg::PH_SECOND;
          end
          bmprle_pkg::PH_SECOND: begin
            phase_nxt = bmprle_pkg::PH_FIRST;
            if (held_c != 8'd0) begin
              // Repeat group: count then value.
              push                = 1'b1;
              push_cmd.run_length = held_c;
              if (col_held_sum > {1'b0, cfg.eff_width}) begin
                fin_nxt       = 1'b1;
                push_cmd.kind = bmprle_pkg::EV_OVERFLOW;
              end else begin
                push_cmd.kind = bmprle_pkg::EV_RUN;
                if (cfg.mode) begin
                  push_cmd.first_pixel  = {4'd0, hi};
                  push_cmd.second_pixel = {4'd0, lo};
                end else begin
                  push_cmd.first_pixel  = in_data_byte;
                  push_cmd.second_pixel = in_data_byte;
                end
                col_nxt = col_held_sum[11:0];
              end
            end else if (in_data_byte == 8'd0) begin
              // End of row; on the last row it ends the image.
              if (row_inc >= {1'b0, cfg.eff_height}) begin
                fin_nxt       = 1'b1;
                push          = 1'b1;
                push_cmd.kind = bmprle_pkg::EV_DONE;
              end else begin
                row_nxt = row_inc[11:0];
                col_nxt = 12'd0;
              end
            end else if (in_data_byte == 8'd1) begin
              fin_nxt       = 1'b1;
              push          = 1'b1;
              push_cmd.kind = bmprle_pkg::EV_DONE;
            end else if (in_data_byte == 8'd2) begin
              fin_nxt       = 1'b1;
              push          = 1'b1;
              push_cmd.kind = bmprle_pkg::EV_DELTA;
            end else if (col_byte_sum > {1'b0, cfg.eff_width}) begin
              fin_nxt             = 1'b1;
              push                = 1'b1;
              push_cmd.kind       = bmprle_pkg::EV_OVERFLOW;
              push_cmd.run_length = in_data_byte;
            end else begin
              // Literal group; data is padded to an even byte count.
              lit_nxt   = in_data_byte;
              pad_nxt   = cfg.mode ? byte_inc[1] : in_data_byte[0];
              phase_nxt = bmprle_pkg::PH_LITERAL;
            end
          end
          bmprle_pkg::PH_LITERAL: begin
            push                = 1'b1;
            push_cmd.kind       = bmprle_pkg::EV_RUN;
            push_cmd.run_length = lit_len;
            if (cfg.mode) begin
              push_cmd.first_pixel  = {4'd0, hi};
              push_cmd.second_pixel = {4'd0, lo};
            end else begin
              push_cmd.first_pixel  = in_data_byte;
              push_cmd.second_pixel = in_data_byte;
            end
            col_nxt = col_c + {4'd0, lit_len};
            lit_nxt = lit_rem;
            if (lit_rem == 8'd0) begin
              phase_nxt = pad_c ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_FIRST;
            end
          end
          bmprle_pkg::PH_PAD: begin
            pad_nxt   = 1'b0;
            phase_nxt = bmprle_pkg::PH_FIRST;
          end
          default: begin
            phase_nxt = bmprle_pkg::PH_FIRST;
          end
        endcase
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bmprle_pkg::PH_FIRST;
      held_r  <= 8'd0;
      lit_r   <= 8'd0;
      pad_r   <= 1'b0;
      col_r   <= 12'd0;
      row_r   <= 12'd0;
      fin_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      lit_r   <= lit_nxt;
      pad_r   <= pad_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

### hw/rtl/bmprle_queue.sv
// ============================================================================
// bmprle_queue: short command queue between parser and output stage
// A small circular buffer that lets the parser run while results wait.
// ============================================================================
module bmprle_queue #(
  parameter int unsigned DEPTH = bmprle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  bmprle_pkg::cmd_t           push_cmd,
  input  logic                       pop,
  output bmprle_pkg::cmd_t           head_cmd,
  output bmprle_pkg::queue_status_t  status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bmprle_pkg::cmd_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign status.full  = (count_r == CNT_FULL);
  assign status.empty = (count_r == '0);
  assign head_cmd     = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Command storage; needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hw/rtl/bmprle_back.sv
// ============================================================================
// bmprle_back: output stage of the decoder
// Takes commands from the queue, flips the file row to the stored bottom-up
// row, and holds each result in a register until the receiver takes it.
// ============================================================================
module bmprle_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmprle_pkg::cfg_t           cfg,
  input  bmprle_pkg::cmd_t           head_cmd,
  input  bmprle_pkg::queue_status_t  status,
  output logic                       pop,
  input  logic                       out_stall,
  output logic                       out_valid,
  output logic [1:0]                 out_event_kind,
  output logic [11:0]                out_row,
  output logic [11:0]                out_column,
  output logic [7:0]                 out_run_length,
  output logic [7:0]                 out_first_pixel,
  output logic [7:0]                 out_second_pixel
);

  logic             valid_r, valid_nxt;
  bmprle_pkg::cmd_t res_r, res_nxt;
  logic [11:0]      stored_row;

  // Load a new result when the register is empty or being taken.
  assign pop        = !status.empty && (!valid_r || !out_stall);
  assign valid_nxt  = pop || (valid_r && out_stall);
  assign stored_row = cfg.eff_height - 12'd1 - head_cmd.row;

  // The head command with its row flipped to the stored row.
  always_comb begin
    res_nxt     = head_cmd;
    res_nxt.row = stored_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = res_r.kind;
  assign out_row          = res_r.row;
  assign out_column       = res_r.column;
  assign out_run_length   = res_r.run_length;
  assign out_first_pixel  = res_r.first_pixel;
  assign out_second_pixel = res_r.second_pixel;

endmodule

### hw/rtl/bmp_rle_pixel_run_decoder_top.sv
// ============================================================================
// bmp_rle_pixel_run_decoder_top: run-length bitmap pixel stream decoder
// Parses 8-bit and 4-bit run-length compressed bytes into fill requests.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_stall   data_byte, image_start
//   out_     output     out_valid / out_stall event_kind, row, column,
//                                             run_length, first/second_pixel
//   cfg_     input      cfg_we                cfg_index, cfg_wdata
//
// One byte request is accepted per cycle; the parser handles it in that cycle.
// A result reaches out_ by way of a queue entry and then the output register.
// Input stalls only while the command queue is full.
// Synchronous active-low reset clears the parser, queue and output valid.
// ============================================================================
module bmp_rle_pixel_run_decoder_top #(
  parameter int unsigned MAX_WIDTH   = bmprle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT  = bmprle_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned QUEUE_DEPTH = bmprle_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_image_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [11:0] out_row,
  output logic [11:0] out_column,
  output logic [7:0]  out_run_length,
  output logic [7:0]  out_first_pixel,
  output logic [7:0]  out_second_pixel,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam logic [16:0] W_CAP = 17'(MAX_WIDTH - 1);
  localparam logic [16:0] H_CAP = 17'(MAX_HEIGHT - 1);

  logic                      mode_r;
  logic [11:0]               width_r;
  logic [11:0]               height_r;
  bmprle_pkg::cfg_t          cfg;
  logic                      in_accept;
  logic                      push;
  logic                      pop;
  bmprle_pkg::cmd_t          push_cmd;
  bmprle_pkg::cmd_t          head_cmd;
  bmprle_pkg::queue_status_t status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      width_r  <= 12'd1;
      height_r <= 12'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bmprle_pkg::REG_MODE:   mode_r   <= cfg_wdata[0];
        bmprle_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        bmprle_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp the image size to the supported limits.
  assign cfg.mode       = mode_r;
  assign cfg.eff_width  = ({5'd0, width_r} > W_CAP) ? W_CAP[11:0] : width_r;
  assign cfg.eff_height = ({5'd0, height_r} > H_CAP) ? H_CAP[11:0] : height_r;

  assign in_stall  = status.full;
  assign in_accept = in_valid && !status.full;

  bmprle_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_data_byte   (in_data_byte),
    .in_image_start (in_image_start),
    .cfg            (cfg),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  bmprle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .status   (status)
  );

  bmprle_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head_cmd         (head_cmd),
    .status           (status),
    .pop              (pop),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_event_kind   (out_event_kind),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_run_length   (out_run_length),
    .out_first_pixel  (out_first_pixel),
    .out_second_pixel (out_second_pixel)
  );

  // The parser never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("command queue written while full");

  // The output stage never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("command queue read while empty");

  // A queued command is always moved on once the output register is free.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!status.empty && !out_valid) |=> out_valid)
    else $error("output stage idle with commands waiting");

endmodule
